// ----- hdl/gwei_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwei_pkg: shared types and constants
// Opcodes, status codes, trigger bits and the result record of the GPIO block.
// ----------------------------------------------------------------------------
package gwei_pkg;

   localparam int NUM_LINES_DEFAULT = 6;

   localparam int OPCODE_W   = 4;
   localparam int LINE_W     = 3;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int PIN_W      = 6;
   localparam int TRIG_W     = 4;
   localparam int CSR_IDX_W  = 4;

   // interrupt-capable lines
   localparam logic [LINE_W-1:0] IRQ_LINE_FOUR = 3'd4;
   localparam logic [LINE_W-1:0] IRQ_LINE_FIVE = 3'd5;

   // trigger bits
   localparam int TRIG_RISE_BIT = 0;
   localparam int TRIG_FALL_BIT = 1;
   localparam int TRIG_HIGH_BIT = 2;
   localparam int TRIG_LOW_BIT  = 3;

   localparam logic [TRIG_W-1:0] TRIG_FOUR_RESET = 4'd2;
   localparam logic [TRIG_W-1:0] TRIG_FIVE_RESET = 4'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_DIR_IN    = 4'd0,
      OP_DIR_OUT   = 4'd1,
      OP_WRITE     = 4'd2,
      OP_READ_LVL  = 4'd3,
      OP_READ_DIR  = 4'd4,
      OP_INJECT    = 4'd5,
      OP_MASK      = 4'd6,
      OP_UNMASK    = 4'd7,
      OP_READ_CNT  = 4'd8,
      OP_READ_TIME = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_NOT_IRQ   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIG_FOUR = 4'd0,
      CSR_TRIG_FIVE = 4'd1
   } csr_idx_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic                irq_pulse;
      logic                irq_source;
      logic [PIN_W-1:0]    pin_levels;
   } rsp_type;

endpackage

// ----- hdl/gwei_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwei_core: line state and access decode
// Holds levels, directions, masks, trigger registers, interrupt count and
// time stamp; decodes one transaction per cycle and forms its result.
// ----------------------------------------------------------------------------
module gwei_core #(
   parameter int NUM_LINES = gwei_pkg::NUM_LINES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [gwei_pkg::OPCODE_W-1:0] opcode,
   input  logic [gwei_pkg::LINE_W-1:0]   line_number,
   input  logic                          level,
   input  logic                          irq_index,
   input  logic [gwei_pkg::DATA_W-1:0]   time_ms,
   input  logic                          csr_write,
   input  logic [gwei_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gwei_pkg::TRIG_W-1:0]   csr_data,
   output gwei_pkg::rsp_type             result
);
   import gwei_pkg::*;

   logic [NUM_LINES-1:0] levels_ff, levels_in;
   logic [NUM_LINES-1:0] dirs_ff, dirs_in;
   logic [1:0]           masks_ff, masks_in;
   logic [DATA_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]    stamp_ff, stamp_in;
   logic [TRIG_W-1:0]    trig_four_ff, trig_five_ff;

   logic                 in_range;
   logic [NUM_LINES-1:0] line_bit;
   logic [NUM_LINES-1:0] levels_wr;
   logic [NUM_LINES-1:0] levels_sh;
   logic [NUM_LINES-1:0] dirs_sh;
   logic                 is_four, is_five;
   logic [TRIG_W-1:0]    trig;
   logic                 old_lvl;
   logic                 fire;
   logic [1:0]           idx_bit;

   assign in_range  = 32'(line_number) < 32'(NUM_LINES);
   assign line_bit  = in_range ? (NUM_LINES'(1) << line_number) : '0;
   assign levels_wr = level ? (levels_ff | line_bit) : (levels_ff & ~line_bit);
   assign levels_sh = levels_ff >> line_number;
   assign dirs_sh   = dirs_ff >> line_number;
   assign is_four   = line_number == IRQ_LINE_FOUR;
   assign is_five   = line_number == IRQ_LINE_FIVE;
   assign trig      = is_five ? trig_five_ff : trig_four_ff;
   assign old_lvl   = levels_sh[0];
   assign idx_bit   = 2'(1) << irq_index;
   assign fire      = (old_lvl && !level && trig[TRIG_FALL_BIT]) ||
                      (!old_lvl && level && trig[TRIG_RISE_BIT]) ||
                      trig[TRIG_HIGH_BIT] || trig[TRIG_LOW_BIT];

   always_comb begin
      levels_in         = levels_ff;
      dirs_in           = dirs_ff;
      masks_in          = masks_ff;
      count_in          = count_ff;
      stamp_in          = stamp_ff;
      result.status     = ST_OK;
      result.read_data  = '0;
      result.irq_pulse  = 1'b0;
      result.irq_source = 1'b0;
      if (opcode <= OP_INJECT && !in_range) begin
         result.status = ST_RANGE;
      end else begin
         unique case (op_type'(opcode))
            OP_DIR_IN: begin
               dirs_in = dirs_ff & ~line_bit;
            end
            OP_DIR_OUT: begin
               dirs_in   = dirs_ff | line_bit;
               levels_in = levels_wr;
            end
            OP_WRITE: begin
               levels_in = levels_wr;
            end
            OP_READ_LVL: begin
               result.read_data = DATA_W'(levels_sh[0]);
            end
            OP_READ_DIR: begin
               result.read_data = DATA_W'(dirs_sh[0]);
            end
            OP_INJECT: begin
               if (!is_four && !is_five) begin
                  result.status = ST_NOT_IRQ;
               end else begin
                  levels_in         = levels_wr;
                  result.irq_source = is_five;
                  if (fire) begin
                     count_in         = count_ff + DATA_W'(1);
                     stamp_in         = time_ms;
                     result.irq_pulse = !masks_ff[is_five];
                  end
               end
            end
            OP_MASK: begin
               masks_in = masks_ff | idx_bit;
            end
            OP_UNMASK: begin
               masks_in = masks_ff & ~idx_bit;
            end
            OP_READ_CNT: begin
               result.read_data = count_ff;
            end
            OP_READ_TIME: begin
               result.read_data = stamp_ff;
            end
            default: begin
            end
         endcase
      end
      result.pin_levels = levels_in[PIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff    <= NUM_LINES'(1) << IRQ_LINE_FOUR;
         dirs_ff      <= '0;
         masks_ff     <= '0;
         count_ff     <= '0;
         stamp_ff     <= '0;
         trig_four_ff <= TRIG_FOUR_RESET;
         trig_five_ff <= TRIG_FIVE_RESET;
      end else begin
         if (accept) begin
            levels_ff <= levels_in;
            dirs_ff   <= dirs_in;
            masks_ff  <= masks_in;
            count_ff  <= count_in;
            stamp_ff  <= stamp_in;
         end
         if (csr_write && csr_index == CSR_TRIG_FOUR) begin
            trig_four_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_TRIG_FIVE) begin
            trig_five_ff <= csr_data;
         end
      end
   end

endmodule

// ----- hdl/gpio_with_edge_interrupts.sv -----
`timescale 1ns / 1ps
// Results are registered in the output register, or in the skid register
// under rsp_stall. Throughput: one transaction per cycle while req_stall is
// low; the two entries keep req_stall registered and absorb one rsp_stall.
// Reset: synchronous, active high; line four high, all else low, both
// interrupts unmasked, triggers falling (line four) and rising (line five).
// ----------------------------------------------------------------------------
// gpio_with_edge_interrupts: six-line GPIO with edge and level interrupts
// Top level: request handshake, configuration writes and result buffering.
// ----------------------------------------------------------------------------
module gpio_with_edge_interrupts #(
   parameter int NUM_LINES = gwei_pkg::NUM_LINES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gwei_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [gwei_pkg::LINE_W-1:0]    req_line_number,
   input  logic                           req_level,
   input  logic                           req_irq_index,
   input  logic [gwei_pkg::DATA_W-1:0]    req_time_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gwei_pkg::STATUS_W-1:0]  rsp_status,
   output logic [gwei_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                           rsp_irq_pulse,
   output logic                           rsp_irq_source,
   output logic [gwei_pkg::PIN_W-1:0]     rsp_pin_levels,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gwei_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gwei_pkg::TRIG_W-1:0]    csr_data
);
   import gwei_pkg::*;

   rsp_type result;
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    accept;
   logic    out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   gwei_core #(
      .NUM_LINES(NUM_LINES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .line_number(req_line_number),
      .level      (req_level),
      .irq_index  (req_irq_index),
      .time_ms    (req_time_ms),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         // drain the skid first, else take the new transaction
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_irq_pulse  = out_ff.irq_pulse;
   assign rsp_irq_source = out_ff.irq_source;
   assign rsp_pin_levels = out_ff.pin_levels;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall) && $past(out_valid_ff))
      else $error("skid filled while the output register was free");

   a_pulse_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.irq_pulse |-> out_ff.status == ST_OK)
      else $error("interrupt pulse on a failed transaction");

endmodule
